// File: rtl/mpd_pkg.sv
`timescale 1ns / 1ps
// Package for the matrix pair distance unit: field widths, register codes and
// the stage structs passed between the pipeline modules. No dependencies.
package mpd_pkg;

  localparam int VAL_W     = 18;
  localparam int IDX_W     = 6;
  localparam int SIZE_W    = 7;
  localparam int MASK_W    = 64;
  localparam int SUM_W     = 42;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int WIDE_W    = 64;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_SIZE   = 2'd0,
    REG_DISTANCE_MODE = 2'd1,
    REG_CLASS_MASK    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] matrix_size;
    logic              sq_mode;
    logic [MASK_W-1:0] class_mask;
  } cfg_state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic [IDX_W-1:0]        row;
    logic                    active;
    logic                    in_class;
    logic                    row_end;
    logic                    last;
    logic                    sq_mode;
  } pair_stage_t;

  typedef struct packed {
    logic [SUM_W-1:0] term;
    logic [IDX_W-1:0] row;
    logic             in_class;
    logic             row_end;
    logic             last;
  } term_stage_t;

endpackage

// File: rtl/mpd_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the matrix pair distance unit: pair input, row result
// output and configuration write. Depends on mpd_pkg.
interface mpd_pair_if import mpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] first_value;
  logic signed [VAL_W-1:0] second_value;
  modport source (output valid, first_value, second_value, input ready);
  modport sink (input valid, first_value, second_value, output ready);
endinterface

interface mpd_row_if import mpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_index;
  logic [SUM_W-1:0] row_distance;
  logic [SUM_W-1:0] class_distance;
  logic             last_row;
  modport source (output valid, row_index, row_distance, class_distance, last_row,
                  input ready);
  modport sink (input valid, row_index, row_distance, class_distance, last_row,
                output ready);
endinterface

interface mpd_cfg_if import mpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/mpd_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: matrix size, distance mode and class mask.
// Depends on mpd_pkg and mpd_cfg_if.
module mpd_cfg_regs import mpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mpd_cfg_if.sink    cfg,
  output cfg_state_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.matrix_size <= SIZE_W'(64);
      regs.sq_mode     <= 1'b0;
      regs.class_mask  <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_MATRIX_SIZE:   regs.matrix_size <= cfg.data[SIZE_W-1:0];
        REG_DISTANCE_MODE: regs.sq_mode     <= cfg.data[0];
        REG_CLASS_MASK:    regs.class_mask  <= cfg.data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/mpd_front.sv
`timescale 1ns / 1ps
// Input stage: row and column counters, position flags and the input register.
// Depends on mpd_pkg and mpd_pair_if.
module mpd_front import mpd_pkg::*; #(
  parameter int MAX_GENES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_state_t  regs,
  input  logic        advance,
  mpd_pair_if.sink    pairs,
  output pair_stage_t p,
  output logic        p_valid
);

  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  row;
  logic [SIZE_W-1:0] size_eff;
  logic [SIZE_W-1:0] last_idx;
  logic              row_end;
  logic              last;
  logic              accept;

  assign pairs.ready = advance;
  assign accept      = pairs.valid && advance;

  always_comb begin
    size_eff = regs.matrix_size;
    if (size_eff < SIZE_W'(2)) size_eff = SIZE_W'(2);
    if (size_eff > SIZE_W'(MAX_GENES)) size_eff = SIZE_W'(MAX_GENES);
    last_idx = size_eff - SIZE_W'(1);
    row_end  = {1'b0, col} >= last_idx;
    last     = {1'b0, row} >= last_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      p_valid <= 1'b0;
    end else if (advance) begin
      p_valid <= accept;
      if (accept) begin
        if (row_end) begin
          col <= '0;
          row <= last ? '0 : row + IDX_W'(1);
        end else begin
          col <= col + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p.a        <= pairs.first_value;
      p.b        <= pairs.second_value;
      p.row      <= row;
      p.active   <= row != col;
      p.in_class <= regs.class_mask[row] && regs.class_mask[col];
      p.row_end  <= row_end;
      p.last     <= last;
      p.sq_mode  <= regs.sq_mode;
    end
  end

endmodule

// File: rtl/mpd_term.sv
`timescale 1ns / 1ps
// Term stage: difference, magnitude, square, scaling to Q.32 and saturation.
// Depends on mpd_pkg.
module mpd_term import mpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  pair_stage_t p,
  input  logic        p_valid,
  output term_stage_t t,
  output logic        t_valid
);

  localparam int ABS_SH = 32 - FRAC_BITS;
  localparam int SQ_SH  = 2 * FRAC_BITS - 32;

  logic signed [VAL_W:0]   diff;
  logic [VAL_W-1:0]        mag;
  logic [2*VAL_W-1:0]      sq;
  logic [WIDE_W-1:0]       abs_wide;
  logic [WIDE_W-1:0]       sq_wide;
  logic [WIDE_W-1:0]       wide;
  logic [SUM_W-1:0]        term;

  always_comb begin
    diff = {p.a[VAL_W-1], p.a} - {p.b[VAL_W-1], p.b};
    mag  = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
    sq   = mag * mag;
  end

  assign abs_wide = WIDE_W'(mag) << ABS_SH;

  generate
    if (SQ_SH >= 0) begin : g_sq_right
      assign sq_wide = WIDE_W'(sq) >> SQ_SH;
    end else begin : g_sq_left
      assign sq_wide = WIDE_W'(sq) << (-SQ_SH);
    end
  endgenerate

  always_comb begin
    wide = p.sq_mode ? sq_wide : abs_wide;
    if (!p.active) term = '0;
    else if (wide > WIDE_W'(SUM_MAX)) term = SUM_MAX;
    else term = wide[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (advance) begin
      t_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && p_valid) begin
      t.term     <= term;
      t.row      <= p.row;
      t.in_class <= p.in_class;
      t.row_end  <= p.row_end;
      t.last     <= p.last;
    end
  end

endmodule

// File: rtl/mpd_accum.sv
`timescale 1ns / 1ps
// Accumulate stage: saturating row and class sums and the result register.
// Depends on mpd_pkg and mpd_row_if.
module mpd_accum import mpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  term_stage_t t,
  input  logic        t_valid,
  output logic        advance,
  mpd_row_if.source   rows
);

  logic [SUM_W-1:0] row_sum;
  logic [SUM_W-1:0] class_sum;
  logic [SUM_W:0]   row_add;
  logic [SUM_W:0]   class_add;
  logic [SUM_W-1:0] row_sum_next;
  logic [SUM_W-1:0] class_sum_next;
  logic             step;

  assign advance = !rows.valid || rows.ready;
  assign step    = advance && t_valid;

  always_comb begin
    row_add        = {1'b0, row_sum} + {1'b0, t.term};
    class_add      = {1'b0, class_sum} + {1'b0, t.term};
    row_sum_next   = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
    class_sum_next = class_sum;
    if (t.in_class) class_sum_next = class_add[SUM_W] ? SUM_MAX : class_add[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum    <= '0;
      class_sum  <= '0;
      rows.valid <= 1'b0;
    end else if (advance) begin
      rows.valid <= t_valid && t.row_end;
      if (t_valid) begin
        row_sum   <= t.row_end ? '0 : row_sum_next;
        class_sum <= (t.row_end && t.last) ? '0 : class_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && t.row_end) begin
      rows.row_index      <= t.row;
      rows.row_distance   <= row_sum_next;
      rows.class_distance <= class_sum_next;
      rows.last_row       <= t.last;
    end
  end

endmodule

// File: rtl/matrix_pair_distance_unit.sv
`timescale 1ns / 1ps
// Matrix pair distance unit: per-row and class-pair difference sums of two
// square matrices. Depends on mpd_pkg, mpd_if and the mpd_* stage modules.
//
// Usage:
//   pairs: one element pair per item, both matrices in row-major order.
//   rows:  one item at the end of each row with the row's off-diagonal sum,
//          the running class sum and last_row on the final row.
//   cfg:   register writes (0 matrix_size, 1 distance_mode, 2 class_mask),
//          always ready; write only while no pair is in flight.
// Throughput: one pair per cycle while no result stalls, using the single
//   multiplier in the term stage and the accumulator loop on the sum registers.
// Path: the input register loads a row's last pair at the edge that accepts it,
//   then the term register and the result register take it in turn.
// Stall: while a result waits on rows.ready the whole pipeline holds and
//   pairs.ready is low; ready returns in the cycle the result is taken.
// Reset: counters and sums clear, matrix_size returns to 64, distance_mode
//   to absolute difference, class_mask to empty.
module matrix_pair_distance_unit import mpd_pkg::*; #(
  parameter int MAX_GENES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  mpd_cfg_if.sink   cfg,
  mpd_pair_if.sink  pairs,
  mpd_row_if.source rows
);

  cfg_state_t  regs;
  pair_stage_t p;
  logic        p_valid;
  term_stage_t t;
  logic        t_valid;
  logic        advance;

  mpd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mpd_front #(.MAX_GENES(MAX_GENES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .advance (advance),
    .pairs   (pairs),
    .p       (p),
    .p_valid (p_valid)
  );

  mpd_term #(.FRAC_BITS(FRAC_BITS)) u_term (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .p       (p),
    .p_valid (p_valid),
    .t       (t),
    .t_valid (t_valid)
  );

  mpd_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .t       (t),
    .t_valid (t_valid),
    .advance (advance),
    .rows    (rows)
  );

endmodule

// File: rtl/mpd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the matrix pair distance unit, bound to the top level.
// Depends on mpd_pkg and matrix_pair_distance_unit.
module mpd_checker import mpd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cfg_ready,
  input logic             pairs_ready,
  input logic             rows_valid,
  input logic             rows_ready,
  input logic [IDX_W-1:0] row_index,
  input logic [SUM_W-1:0] row_distance
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rows_valid)
    else $error("result valid right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rows_valid && !rows_ready) |-> !pairs_ready)
    else $error("pair taken while result stalls");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rows_valid && !rows_ready) |=> (rows_valid && $stable(row_index)
                                     && $stable(row_distance)))
    else $error("stalled result changed");

endmodule

bind matrix_pair_distance_unit mpd_checker u_mpd_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_ready    (cfg.ready),
  .pairs_ready  (pairs.ready),
  .rows_valid   (rows.valid),
  .rows_ready   (rows.ready),
  .row_index    (rows.row_index),
  .row_distance (rows.row_distance)
);
